// File: rtl/cau_pkg.sv
// shared types, opcodes, status codes and datapath helpers for the complex arithmetic unit
// no dependencies
`default_nettype none

package cau_pkg;

  localparam int CAU_FRAC_BITS = 16;
  localparam int CAU_DIV_BITS  = 32;

  localparam logic [2:0] OP_NEG  = 3'd0;
  localparam logic [2:0] OP_INV  = 3'd1;
  localparam logic [2:0] OP_CONJ = 3'd2;
  localparam logic [2:0] OP_ADD  = 3'd3;
  localparam logic [2:0] OP_SUB  = 3'd4;
  localparam logic [2:0] OP_MUL  = 3'd5;
  localparam logic [2:0] OP_DIV  = 3'd6;
  localparam logic [2:0] OP_RSVD = 3'd7;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_DIV0 = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] a_real;
    logic signed [31:0] a_imag;
    logic signed [31:0] b_real;
    logic signed [31:0] b_imag;
  } cau_req_t;

  typedef struct packed {
    logic signed [31:0] res_real;
    logic signed [31:0] res_imag;
    logic [1:0]         status;
  } cau_res_t;

  // one component on its way through the divider
  typedef struct packed {
    logic        neg;
    logic        big;
    logic [63:0] rem;
    logic [31:0] low;
    logic [31:0] quo;
  } cau_lane_t;

  // control that travels with each transaction through the divider
  typedef struct packed {
    logic        valid;
    logic        is_div;
    logic        div0;
    logic [2:0]  opcode;
    logic [63:0] den;
  } cau_div_ctl_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] val;
  } cau_sat_t;

  // one restoring step: shift in the next numerator bit, subtract when it fits
  function automatic cau_lane_t cau_div_step(cau_lane_t l, logic [63:0] den, logic en);
    logic [64:0] trial;
    logic        fit;
    cau_lane_t   r;
    r     = l;
    trial = {l.rem, l.low[31]};
    fit   = (trial >= {1'b0, den});
    if (en) begin
      r.rem = fit ? 64'(trial - {1'b0, den}) : trial[63:0];
      r.low = {l.low[30:0], 1'b0};
      r.quo = {l.quo[30:0], fit};
    end
    return r;
  endfunction

  function automatic cau_sat_t cau_sat(cau_lane_t l);
    cau_sat_t s;
    s.ovf = 1'b0;
    if (l.neg) begin
      if (l.big || l.quo > 32'h8000_0000) begin
        s.ovf = 1'b1;
        s.val = 32'h8000_0000;
      end else begin
        s.val = 32'(-l.quo);
      end
    end else begin
      if (l.big || l.quo[31]) begin
        s.ovf = 1'b1;
        s.val = 32'h7FFF_FFFF;
      end else begin
        s.val = l.quo;
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/cau_div_pipe.sv
// pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor
// depends on cau_pkg
`default_nettype none

module cau_div_pipe (
  input  wire                    clk,
  input  wire                    rst,
  input  cau_pkg::cau_div_ctl_t  ctl_in,
  input  cau_pkg::cau_lane_t     re_in,
  input  cau_pkg::cau_lane_t     im_in,
  output cau_pkg::cau_div_ctl_t  ctl_out,
  output cau_pkg::cau_lane_t     re_out,
  output cau_pkg::cau_lane_t     im_out
);
  import cau_pkg::*;

  cau_div_ctl_t ctl [0:CAU_DIV_BITS];
  cau_lane_t    re  [0:CAU_DIV_BITS];
  cau_lane_t    im  [0:CAU_DIV_BITS];

  assign ctl[0] = ctl_in;
  assign re[0]  = re_in;
  assign im[0]  = im_in;

  for (genvar i = 0; i < CAU_DIV_BITS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl[i+1].valid <= 1'b0;
      end else begin
        ctl[i+1].valid <= ctl[i].valid;
      end
      ctl[i+1].is_div <= ctl[i].is_div;
      ctl[i+1].div0   <= ctl[i].div0;
      ctl[i+1].opcode <= ctl[i].opcode;
      ctl[i+1].den    <= ctl[i].den;
      re[i+1]  <= cau_div_step(re[i], ctl[i].den, ctl[i].is_div);
      im[i+1]  <= cau_div_step(im[i], ctl[i].den, ctl[i].is_div);
    end
  end

  assign ctl_out = ctl[CAU_DIV_BITS];
  assign re_out  = re[CAU_DIV_BITS];
  assign im_out  = im[CAU_DIV_BITS];

endmodule

`default_nettype wire

// File: rtl/complex_arith_unit.sv
// complex arithmetic unit top level: operand mux, multipliers, sums, magnitude, divider, saturation
// depends on cau_pkg and cau_div_pipe
// a result strobes on done after stages 0 to 4, the divider stages and the output register
// throughput: one transaction per cycle, set by the 32-stage divider with one quotient bit per stage
// busy stays low; the pipeline always advances since results cannot be held off
// reset (synchronous) clears only the valid bits; data registers keep running
`default_nettype none

module complex_arith_unit #(
  parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  cau_pkg::cau_req_t  operands,
  output logic               done,
  output cau_pkg::cau_res_t  result
);
  import cau_pkg::*;

  localparam int SH = 32 - FRAC_BITS;
  localparam int NW = 64 + FRAC_BITS;

  logic accept;
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // stage 0: operand selection
  logic signed [31:0] xr, xi, yr, yi;
  logic               div0_in;
  always_comb begin
    xr = operands.a_real;
    xi = operands.a_imag;
    yr = operands.b_real;
    yi = operands.b_imag;
    if (operands.opcode == OP_INV) begin
      xr = 32'sd1 <<< FRAC_BITS;
      xi = '0;
      yr = operands.a_real;
      yi = operands.a_imag;
    end
    div0_in = (operands.opcode == OP_INV && operands.a_real == 0 && operands.a_imag == 0) ||
              (operands.opcode == OP_DIV && operands.b_real == 0 && operands.b_imag == 0);
  end

  logic               v0;
  cau_req_t           s0_req;
  logic signed [31:0] s0_xr, s0_xi, s0_yr, s0_yi;
  logic               s0_div0;
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else begin
      v0 <= accept;
    end
    s0_req  <= operands;
    s0_xr   <= xr;
    s0_xi   <= xi;
    s0_yr   <= yr;
    s0_yi   <= yi;
    s0_div0 <= div0_in;
  end

  // stage 1: products
  logic               v1;
  cau_req_t           s1_req;
  logic               s1_div0;
  logic signed [63:0] s1_prr, s1_pii, s1_pri, s1_pir, s1_dr, s1_di;
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= v0;
    end
    s1_req  <= s0_req;
    s1_div0 <= s0_div0;
    s1_prr  <= s0_xr * s0_yr;
    s1_pii  <= s0_xi * s0_yi;
    s1_pri  <= s0_xr * s0_yi;
    s1_pir  <= s0_xi * s0_yr;
    s1_dr   <= s0_yr * s0_yr;
    s1_di   <= s0_yi * s0_yi;
  end

  // stage 2: exact sums per opcode
  logic signed [64:0] re_sum, im_sum;
  always_comb begin
    case (s1_req.opcode)
      OP_NEG: begin
        re_sum = -65'(s1_req.a_real);
        im_sum = -65'(s1_req.a_imag);
      end
      OP_CONJ: begin
        re_sum = 65'(s1_req.a_real);
        im_sum = -65'(s1_req.a_imag);
      end
      OP_ADD: begin
        re_sum = 65'(s1_req.a_real) + 65'(s1_req.b_real);
        im_sum = 65'(s1_req.a_imag) + 65'(s1_req.b_imag);
      end
      OP_SUB: begin
        re_sum = 65'(s1_req.a_real) - 65'(s1_req.b_real);
        im_sum = 65'(s1_req.a_imag) - 65'(s1_req.b_imag);
      end
      OP_MUL: begin
        re_sum = 65'(s1_prr) - 65'(s1_pii);
        im_sum = 65'(s1_pri) + 65'(s1_pir);
      end
      OP_INV, OP_DIV: begin
        re_sum = 65'(s1_prr) + 65'(s1_pii);
        im_sum = 65'(s1_pir) - 65'(s1_pri);
      end
      default: begin
        re_sum = '0;
        im_sum = '0;
      end
    endcase
  end

  logic               v2;
  logic [2:0]         s2_op;
  logic               s2_div0;
  logic signed [64:0] s2_re, s2_im;
  logic [63:0]        s2_den;
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    s2_op   <= s1_req.opcode;
    s2_div0 <= s1_div0;
    s2_re   <= re_sum;
    s2_im   <= im_sum;
    s2_den  <= $unsigned(s1_dr) + $unsigned(s1_di);
  end

  // stage 3: sign and magnitude; multiply truncates toward zero on the magnitude
  logic [63:0] re_mag, im_mag;
  always_comb begin
    re_mag = s2_re[64] ? 64'(-s2_re) : s2_re[63:0];
    im_mag = s2_im[64] ? 64'(-s2_im) : s2_im[63:0];
    if (s2_op == OP_MUL) begin
      re_mag = re_mag >> FRAC_BITS;
      im_mag = im_mag >> FRAC_BITS;
    end
  end

  logic        v3;
  logic [2:0]  s3_op;
  logic        s3_div0;
  logic        s3_re_neg, s3_im_neg;
  logic [63:0] s3_re_mag, s3_im_mag, s3_den;
  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    s3_op     <= s2_op;
    s3_div0   <= s2_div0;
    s3_re_neg <= s2_re[64];
    s3_im_neg <= s2_im[64];
    s3_re_mag <= re_mag;
    s3_im_mag <= im_mag;
    s3_den    <= s2_den;
  end

  // stage 4: quotient range check and divider load
  logic         s3_is_div;
  cau_lane_t    re_lane, im_lane;
  logic [NW-1:0] re_num, im_num;
  assign s3_is_div = (s3_op == OP_INV) || (s3_op == OP_DIV);
  assign re_num    = {s3_re_mag, {FRAC_BITS{1'b0}}};
  assign im_num    = {s3_im_mag, {FRAC_BITS{1'b0}}};

  always_comb begin
    re_lane.neg = s3_re_neg;
    im_lane.neg = s3_im_neg;
    if (s3_is_div) begin
      // quotient of 2^32 or more saturates either way
      re_lane.big = {{SH{1'b0}}, s3_re_mag} >= {s3_den, {SH{1'b0}}};
      im_lane.big = {{SH{1'b0}}, s3_im_mag} >= {s3_den, {SH{1'b0}}};
      re_lane.rem = 64'(re_num[NW-1:32]);
      im_lane.rem = 64'(im_num[NW-1:32]);
      re_lane.low = re_num[31:0];
      im_lane.low = im_num[31:0];
      re_lane.quo = '0;
      im_lane.quo = '0;
    end else begin
      re_lane.big = |s3_re_mag[63:32];
      im_lane.big = |s3_im_mag[63:32];
      re_lane.rem = '0;
      im_lane.rem = '0;
      re_lane.low = '0;
      im_lane.low = '0;
      re_lane.quo = s3_re_mag[31:0];
      im_lane.quo = s3_im_mag[31:0];
    end
  end

  cau_div_ctl_t s4_ctl;
  cau_lane_t    s4_re, s4_im;
  always_ff @(posedge clk) begin
    if (rst) begin
      s4_ctl.valid <= 1'b0;
    end else begin
      s4_ctl.valid <= v3;
    end
    s4_ctl.is_div <= s3_is_div;
    s4_ctl.div0   <= s3_div0;
    s4_ctl.opcode <= s3_op;
    s4_ctl.den    <= s3_den;
    s4_re         <= re_lane;
    s4_im         <= im_lane;
  end

  cau_div_ctl_t dv_ctl;
  cau_lane_t    dv_re, dv_im;

  cau_div_pipe u_div (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (s4_ctl),
    .re_in   (s4_re),
    .im_in   (s4_im),
    .ctl_out (dv_ctl),
    .re_out  (dv_re),
    .im_out  (dv_im)
  );

  // final stage: saturation and status
  cau_sat_t sat_re, sat_im;
  cau_res_t res_next;
  always_comb begin
    sat_re = cau_sat(dv_re);
    sat_im = cau_sat(dv_im);
    res_next.res_real = sat_re.val;
    res_next.res_imag = sat_im.val;
    res_next.status   = (sat_re.ovf || sat_im.ovf) ? ST_OVF : ST_OK;
    if (dv_ctl.div0) begin
      res_next.res_real = '0;
      res_next.res_imag = '0;
      res_next.status   = ST_DIV0;
    end else if (dv_ctl.opcode == OP_RSVD) begin
      res_next.res_real = '0;
      res_next.res_imag = '0;
      res_next.status   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_ctl.valid;
    end
    result <= res_next;
  end

`ifndef SYNTH
  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_DIV0 |-> result.res_real == 0 && result.res_imag == 0)
    else $error("divide by zero transaction with nonzero result");

  a_ovf_sat: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_OVF |->
      result.res_real == 32'sh7FFF_FFFF || result.res_real == 32'sh8000_0000 ||
      result.res_imag == 32'sh7FFF_FFFF || result.res_imag == 32'sh8000_0000)
    else $error("overflow status without a saturated component");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.status != 2'd3)
    else $error("undefined status code");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");
`endif

endmodule

`default_nettype wire
